>>> rtl/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants of the duplicate segment detector
// Sizes of the segment store, normal-form segment type, chain link type,
// control bundle for the cells, and the action and status codes.
// ----------------------------------------------------------------------------
package dsd_pkg;

  // store depth and coordinate width
  localparam int MAX_SEGMENTS = 256;
  localparam int COORD_BITS   = 32;

  // derived widths
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SEQ_W = 16;

  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SEGMENTS);

  // action codes
  localparam logic ACT_SEGMENT = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_CLEARED = 2'd2;

  // segment in normal form: lower endpoint first
  typedef struct packed {
    logic signed [COORD_BITS-1:0] lo_x;
    logic signed [COORD_BITS-1:0] lo_y;
    logic signed [COORD_BITS-1:0] hi_x;
    logic signed [COORD_BITS-1:0] hi_y;
  } seg_t;

  // running match result passed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [SEQ_W-1:0] num;
  } link_t;

  // store control broadcast to every cell
  typedef struct packed {
    logic             wr_en;
    logic [SEQ_W-1:0] wr_num;
    logic [CNT_W-1:0] stored_count;
  } cell_ctl_t;

endpackage

>>> rtl/dsd_norm.sv
// ----------------------------------------------------------------------------
// dsd_norm: segment normalizer
// Orders the two endpoints so that the lower one (smaller x, then smaller y)
// comes first, using the low COORD_BITS bits as two's complement values.
// ----------------------------------------------------------------------------
module dsd_norm (
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  output dsd_pkg::seg_t      seg_o
);
  import dsd_pkg::*;

  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic                         start_low;

  // trim to the coordinate width
  assign sx = start_x_i[COORD_BITS-1:0];
  assign sy = start_y_i[COORD_BITS-1:0];
  assign ex = end_x_i[COORD_BITS-1:0];
  assign ey = end_y_i[COORD_BITS-1:0];

  // lexicographic signed compare
  assign start_low = (sx < ex) || ((sx == ex) && (sy < ey));

  // swap endpoints when the end point is lower
  always_comb begin
    if (start_low) begin
      seg_o.lo_x = sx;
      seg_o.lo_y = sy;
      seg_o.hi_x = ex;
      seg_o.hi_y = ey;
    end else begin
      seg_o.lo_x = ex;
      seg_o.lo_y = ey;
      seg_o.hi_x = sx;
      seg_o.hi_y = sy;
    end
  end

endmodule

>>> rtl/dsd_cell.sv
// ----------------------------------------------------------------------------
// dsd_cell: one store entry of the compare chain
// Holds one unique segment and its number, compares it with the broadcast
// query and forwards the registered running match result to the next cell.
// ----------------------------------------------------------------------------
module dsd_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dsd_pkg::IDX_W-1:0]      cell_idx_i,
  input  dsd_pkg::cell_ctl_t             ctl_i,
  input  dsd_pkg::seg_t                  query_i,
  input  dsd_pkg::link_t                 link_i,
  output dsd_pkg::link_t                 link_o
);
  import dsd_pkg::*;

  seg_t             entry_q;
  logic [SEQ_W-1:0] num_q;
  logic             in_use;
  logic             match;
  logic             wr_here;
  link_t            link_d, link_q;

  // entry is live when its index is below the fill level
  assign in_use  = CNT_W'(cell_idx_i) < ctl_i.stored_count;
  assign match   = in_use && (entry_q == query_i);
  assign wr_here = ctl_i.wr_en && (CNT_W'(cell_idx_i) == ctl_i.stored_count);

  // entry write at the fill position
  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      entry_q <= query_i;
      num_q   <= ctl_i.wr_num;
    end
  end

  // merge own compare into the running result
  always_comb begin
    link_d = link_i;
    if (!link_i.hit && match) begin
      link_d.hit = 1'b1;
      link_d.num = num_q;
    end
  end

  // link register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

>>> rtl/duplicate_segment_detector_unit.sv
// ----------------------------------------------------------------------------
// duplicate_segment_detector_unit: duplicate line segment detector
// Normalizes each segment, searches a chain of store cells for an identical
// earlier segment, stores new unique segments and reports the match; a clear empties the store.
//
//   channel  signals                                   direction
//   input    in_valid_i / in_ready_o, action_i,        in
//            start_x_i, start_y_i, end_x_i, end_y_i
//   output   out_valid_o / out_ready_i, overlap_o,     out
//            segment_number_o, first_number_o, status_o
//
// A segment passes the accept, one pass of the match result down the
// MAX_SEGMENTS-cell chain, and the finish step. A clear goes from the accept
// straight to the finish step. One word is in work at a time.
// Reset empties the store count and the segment counter; no clearing pass.
// A new word is accepted while a result still waits; the finish cycle
// waits for the output register to be free.
// ----------------------------------------------------------------------------
module duplicate_segment_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        overlap_o,
  output logic [15:0] segment_number_o,
  output logic [15:0] first_number_o,
  output logic [1:0]  status_o
);
  import dsd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SEQ_W-1:0] seen_q, seen_d, seen_next;

  seg_t             norm_seg;
  seg_t             query_q;
  logic             clear_q;

  logic             in_fire;
  logic             fin_go;
  logic             store_new;

  cell_ctl_t        ctl;
  link_t            links [MAX_SEGMENTS+1];
  link_t            tail;

  logic             out_valid_q;
  logic             overlap_q;
  logic [SEQ_W-1:0] seg_num_q;
  logic [SEQ_W-1:0] first_q;
  logic [1:0]       status_q;

  // input handshake
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // endpoint ordering
  dsd_norm u_norm (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .seg_o     (norm_seg)
  );

  // query register, stable for the whole search
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      query_q <= norm_seg;
      clear_q <= (action_i == ACT_CLEAR);
    end
  end

  // compare chain
  assign links[0] = '0;

  for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
    dsd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(gi)),
      .ctl_i      (ctl),
      .query_i    (query_q),
      .link_i     (links[gi]),
      .link_o     (links[gi+1])
    );
  end

  assign tail = links[MAX_SEGMENTS];

  // finish step and store decision
  assign fin_go    = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign seen_next = (seen_q == SEQ_MAX) ? seen_q : seen_q + SEQ_W'(1);
  assign store_new = fin_go && !clear_q && !tail.hit && (count_q != CNT_FULL);

  assign ctl.wr_en        = store_new;
  assign ctl.wr_num       = seen_next;
  assign ctl.stored_count = count_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    seen_d  = seen_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_fire) begin
          state_d = (action_i == ACT_CLEAR) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (step_q == IDX_W'(MAX_SEGMENTS - 1)) begin
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_d = ST_IDLE;
          if (clear_q) begin
            count_d = '0;
            seen_d  = '0;
          end else begin
            seen_d = seen_next;
            if (store_new) begin
              count_d = count_q + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      seen_q  <= seen_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      if (clear_q) begin
        overlap_q <= 1'b0;
        seg_num_q <= '0;
        first_q   <= '0;
        status_q  <= STATUS_CLEARED;
      end else begin
        overlap_q <= tail.hit;
        seg_num_q <= seen_next;
        first_q   <= tail.hit ? tail.num : '0;
        status_q  <= (tail.hit || (count_q != CNT_FULL)) ? STATUS_OK : STATUS_FULL;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign overlap_o        = overlap_q;
  assign segment_number_o = seg_num_q;
  assign first_number_o   = first_q;
  assign status_o         = status_q;

  // fill level never passes the store depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("store fill level above depth");

  // a full status only appears with a full store
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == STATUS_FULL)) |-> (count_q == CNT_FULL) && !overlap_q)
    else $error("full status without full store");

  // a match names a nonzero segment number no later than its own
  a_match_num : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && overlap_q) |->
      (first_q != '0) && (first_q <= seg_num_q) && (status_q == STATUS_OK))
    else $error("bad matching segment number");

  // the sequencer only leaves idle on an accepted word
  a_search_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !in_fire) |=> (state_q == ST_IDLE))
    else $error("sequencer left idle without an input word");

endmodule

>>> test/duplicate_segment_checker.sv
// ----------------------------------------------------------------------------
// duplicate_segment_checker: result checker for the duplicate segment detector
// Watches both channels, keeps its own segment store and counters to predict
// the result of every accepted input word, and compares each accepted result
// word field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module duplicate_segment_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [31:0] start_x_i,
  input  logic [31:0] start_y_i,
  input  logic [31:0] end_x_i,
  input  logic [31:0] end_y_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        overlap_i,
  input  logic [15:0] segment_number_i,
  input  logic [15:0] first_number_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsd_pkg::*;

  localparam int REPORT_MAX = 10;

  // one result word as the block reports it
  typedef struct packed {
    logic             overlap;
    logic [SEQ_W-1:0] seg_num;
    logic [SEQ_W-1:0] first_num;
    logic [1:0]       status;
  } verdict_t;

  // model of the unique segment store
  seg_t             unique_seg [MAX_SEGMENTS];
  logic [SEQ_W-1:0] unique_num [MAX_SEGMENTS];
  int               unique_n;
  logic [SEQ_W-1:0] seen_n;

  verdict_t verdict_q [$];
  int       fail_n;
  int       result_n;

  // updates the store model with one input word and returns its verdict
  function automatic verdict_t classify_segment(input logic act,
                                                input logic [31:0] ax_raw,
                                                input logic [31:0] ay_raw,
                                                input logic [31:0] bx_raw,
                                                input logic [31:0] by_raw);
    verdict_t                     v;
    seg_t                         s;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    v = '0;
    if (act == ACT_CLEAR) begin
      unique_n = 0;
      seen_n   = '0;
      v.status = STATUS_CLEARED;
      return v;
    end
    if (seen_n != SEQ_MAX) seen_n = seen_n + 1'b1;
    ax = ax_raw[COORD_BITS-1:0];
    ay = ay_raw[COORD_BITS-1:0];
    bx = bx_raw[COORD_BITS-1:0];
    by = by_raw[COORD_BITS-1:0];
    // lower endpoint: smaller x, then smaller y, both signed
    if (ax < bx || (ax == bx && ay < by)) begin
      s = {ax, ay, bx, by};
    end else begin
      s = {bx, by, ax, ay};
    end
    v.seg_num = seen_n;
    v.status  = STATUS_OK;
    // duplicates are never stored, so at most one entry hits
    for (int i = 0; i < unique_n; i++) begin
      if (unique_seg[i] == s) begin
        v.overlap   = 1'b1;
        v.first_num = unique_num[i];
        return v;
      end
    end
    if (unique_n < MAX_SEGMENTS) begin
      unique_seg[unique_n] = s;
      unique_num[unique_n] = seen_n;
      unique_n++;
    end else begin
      v.status = STATUS_FULL;
    end
    return v;
  endfunction

  // predict on input handshakes, compare on output handshakes
  always @(posedge clk_i) begin
    verdict_t want, got;
    if (!rst_ni) begin
      unique_n = 0;
      seen_n   = '0;
      verdict_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        verdict_q.push_back(classify_segment(action_i, start_x_i, start_y_i,
                                             end_x_i, end_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = {overlap_i, segment_number_i, first_number_i, status_i};
        result_n++;
        if (verdict_q.size() == 0) begin
          fail_n++;
          if (fail_n <= REPORT_MAX) begin
            $display("result %0d unexpected: overlap %0b seg %0d first %0d status %0d",
                     result_n, got.overlap, got.seg_num, got.first_num, got.status);
          end
        end else begin
          want = verdict_q.pop_front();
          if (got.overlap !== want.overlap || got.seg_num !== want.seg_num ||
              got.first_num !== want.first_num || got.status !== want.status) begin
            fail_n++;
            if (fail_n <= REPORT_MAX) begin
              $display("result %0d mismatch: expected overlap %0b seg %0d first %0d status %0d",
                       result_n, want.overlap, want.seg_num, want.first_num, want.status);
              $display("  actual overlap %0b seg %0d first %0d status %0d",
                       got.overlap, got.seg_num, got.first_num, got.status);
            end
          end
        end
      end
    end
    fail_count_o = fail_n;
    pending_o    = verdict_q.size();
  end

endmodule

>>> test/duplicate_segment_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// duplicate_segment_detector_unit_tb: testbench of the duplicate segment detector
// Drives directed segments (normal-form ordering, zero length, signed extremes,
// clears), fills the store past its depth, then random segments drawn from small
// point pools so duplicates are frequent, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module duplicate_segment_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned PHASE_WORDS  = 225;
  localparam int unsigned FILL_WORDS   = MAX_SEGMENTS + MAX_SEGMENTS / 4 + 16;
  localparam int unsigned TAIL_CYCLES  = MAX_SEGMENTS + 16;
  localparam int unsigned POOL_N       = 6;
  localparam logic [31:0] C_MIN        = 32'h8000_0000;
  localparam logic [31:0] C_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] C_NEG1       = 32'hFFFF_FFFF;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [31:0] ax, ay, bx, by;
  } seg_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_SEGMENT;
  logic [31:0] start_x = '0;
  logic [31:0] start_y = '0;
  logic [31:0] end_x = '0;
  logic [31:0] end_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        overlap;
  logic [15:0] segment_number;
  logic [15:0] first_number;
  logic [1:0]  status;

  int          fail_count;
  int          pending;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_n = 0;
  int unsigned cycle_n = 0;
  logic [31:0] pool_x [POOL_N];
  logic [31:0] pool_y [POOL_N];

  duplicate_segment_detector_unit u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .start_x_i        (start_x),
    .start_y_i        (start_y),
    .end_x_i          (end_x),
    .end_y_i          (end_y),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .overlap_o        (overlap),
    .segment_number_o (segment_number),
    .first_number_o   (first_number),
    .status_o         (status)
  );

  duplicate_segment_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .start_x_i        (start_x),
    .start_y_i        (start_y),
    .end_x_i          (end_x),
    .end_y_i          (end_y),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .overlap_i        (overlap),
    .segment_number_i (segment_number),
    .first_number_i   (first_number),
    .status_i         (status),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: short random stalls, rare long ones that back up the block
  always @(negedge clk) begin
    if (hold_n != 0) begin
      hold_n    <= hold_n - 1;
      out_ready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(0, 499) == 0) begin
      hold_n    <= $urandom_range(50, 2 * MAX_SEGMENTS + 64);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        in_idle_pct = 0;  out_stall_pct = 0;
      end
      IDLE_SENDER: begin
        in_idle_pct = 71; out_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        in_idle_pct = 0;  out_stall_pct = 71;
      end
      default: begin
        in_idle_pct = 10; out_stall_pct = 10;
      end
    endcase
  endtask

  // present one word at a falling edge and hold it until accepted
  task automatic send_word(input logic act, input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] bx, input logic [31:0] by);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_SEGMENTS + 16)
                                        : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    start_x  <= ax;
    start_y  <= ay;
    end_x    <= bx;
    end_y    <= by;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // coordinate with a bias toward the signed extremes
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return C_NEG1;
      default: return $urandom;
    endcase
  endfunction

  task automatic new_pool();
    for (int i = 0; i < POOL_N; i++) begin
      pool_x[i] = pick_coord();
      // shared x values exercise the y tie-break
      pool_y[i] = pick_coord();
      if (i != 0 && $urandom_range(0, 2) == 0) pool_x[i] = pool_x[i-1];
    end
  endtask

  // more unique segments than the store holds, with copies mixed in
  task automatic fill_store();
    seg_word_t w;
    seg_word_t kept [$];
    send_word(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int unsigned k = 0; k < FILL_WORDS; k++) begin
      if (kept.size() > 8 && $urandom_range(0, 5) == 0) begin
        w = kept[$urandom_range(0, kept.size() - 1)];
        if ($urandom_range(0, 1) == 0) send_word(ACT_SEGMENT, w.bx, w.by, w.ax, w.ay);
        else send_word(ACT_SEGMENT, w.ax, w.ay, w.bx, w.by);
      end else begin
        w.ax = $urandom;
        w.ay = $urandom;
        w.bx = $urandom;
        w.by = $urandom;
        kept.push_back(w);
        send_word(ACT_SEGMENT, w.ax, w.ay, w.bx, w.by);
      end
    end
  endtask

  // mostly pool segments, some near misses, random ones and clears
  task automatic random_words(input int unsigned count);
    logic [31:0] c [4];
    int unsigned pick, a, b;
    new_pool();
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) == 0) drain_results();
      pick = $urandom_range(0, 99);
      a = $urandom_range(0, POOL_N - 1);
      b = $urandom_range(0, POOL_N - 1);
      c = '{pool_x[a], pool_y[a], pool_x[b], pool_y[b]};
      if (pick < 3) begin
        send_word(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
        new_pool();
      end else if (pick < 15) begin
        c[$urandom_range(0, 3)] ^= 32'h1 << $urandom_range(0, 31);
        send_word(ACT_SEGMENT, c[0], c[1], c[2], c[3]);
      end else if (pick < 25) begin
        send_word(ACT_SEGMENT, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_word(ACT_SEGMENT, c[0], c[1], c[2], c[3]);
      end
    end
  endtask

  task automatic run_phase(input idle_mode_e mode);
    set_idling(mode);
    if (mode == IDLE_NONE) fill_store();
    random_words(PHASE_WORDS);
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: clear on empty store, normal-form ordering, zero length
    set_idling(IDLE_NONE);
    send_word(ACT_CLEAR, C_NEG1, C_NEG1, C_NEG1, C_NEG1);
    send_word(ACT_SEGMENT, 32'd1, 32'd2, 32'd3, 32'd4);
    send_word(ACT_SEGMENT, 32'd3, 32'd4, 32'd1, 32'd2);
    send_word(ACT_SEGMENT, 32'd5, 32'd5, 32'd5, 32'd5);
    send_word(ACT_SEGMENT, 32'd5, 32'd5, 32'd5, 32'd5);
    send_word(ACT_SEGMENT, 32'd7, 32'd9, 32'd7, 32'd8);
    send_word(ACT_SEGMENT, 32'd7, 32'd8, 32'd7, 32'd9);
    send_word(ACT_SEGMENT, 32'd1, 32'd2, 32'd3, 32'd5);
    // signed extremes
    send_word(ACT_SEGMENT, C_MIN, C_MIN, C_MAX, C_MAX);
    send_word(ACT_SEGMENT, C_MAX, C_MAX, C_MIN, C_MIN);
    send_word(ACT_SEGMENT, C_MAX, C_MIN, C_MIN, C_MAX);
    send_word(ACT_SEGMENT, C_MIN, C_MAX, C_MAX, C_MIN);
    send_word(ACT_SEGMENT, C_NEG1, 32'd0, 32'd0, C_NEG1);
    send_word(ACT_SEGMENT, 32'd0, C_NEG1, C_NEG1, 32'd0);
    send_word(ACT_SEGMENT, C_NEG1, C_NEG1, C_NEG1, C_NEG1);
    send_word(ACT_SEGMENT, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
    // clear restarts numbering and forgets stored segments
    send_word(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    send_word(ACT_SEGMENT, 32'd1, 32'd2, 32'd3, 32'd4);
    send_word(ACT_SEGMENT, 32'd3, 32'd4, 32'd1, 32'd2);
    drain_results();

    run_phase(IDLE_NONE);
    run_phase(IDLE_SENDER);
    run_phase(IDLE_RECEIVER);
    run_phase(IDLE_BOTH);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dsd_pkg.sv
rtl/dsd_norm.sv
rtl/dsd_cell.sv
rtl/duplicate_segment_detector_unit.sv
test/duplicate_segment_checker.sv
test/duplicate_segment_detector_unit_tb.sv
